[hdl/bdq_pkg.sv]
package bdq_pkg;

  localparam int DEF_CAPACITY = 16;

  localparam int FUNC_W   = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 5;

  // operation codes carried on func
  localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd1;
  localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DEL_FIRST  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_DEL_ALL    = 3'd5;
  localparam logic [FUNC_W-1:0] FN_READ_OUT   = 3'd6;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD,
    S_CMP,
    S_OUT,
    S_DONE
  } state_t;

endpackage

[hdl/bdq_ram.sv]
module bdq_ram #(
  parameter int DEPTH = bdq_pkg::DEF_CAPACITY,
  parameter int AW    = $clog2(bdq_pkg::DEF_CAPACITY)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [bdq_pkg::DATA_W-1:0]  wdata,
  input  logic [AW-1:0]               raddr,
  output logic [bdq_pkg::DATA_W-1:0]  rdata
);
  import bdq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hdl/bounded_deque_with_key_delete.sv]
// Bounded deque of up to CAPACITY signed 32-bit values, front first, kept in a
// circular buffer (head pointer plus count) in a single-port-write,
// single-port-read RAM with registered read data. func selects push back, push
// front, pop front, pop back, delete first match of value, delete every match
// of value, or read out; code 7 does nothing and reports done. Every operation
// gives one result with last set, except a read out of a non-empty store,
// which gives one result per element, front first, last on the final one.
// Timing: the item is taken in the idle state and a push, a pop or an unused
// code has its result registered from the execute state once the output
// register is free. A delete walks the whole store through the one shared
// address adder and comparator: after the transfer and a set-up state, each
// element is read from RAM, then compared and, if kept, written back to the
// compacted position; an end-of-walk check then leads to the result. A read
// out reads each element from the RAM, then presents it once the output is
// free. in_ready is high only while no item is in progress; a finished result
// may still wait in the output register while the next item is transferred.
// Removed count and new length are reported modulo 32.
module bounded_deque_with_key_delete #(
  parameter int CAPACITY = bdq_pkg::DEF_CAPACITY
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic        [bdq_pkg::FUNC_W-1:0]    func,
  input  logic signed [bdq_pkg::DATA_W-1:0]    value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic        [bdq_pkg::STATUS_W-1:0]  status,
  output logic        [bdq_pkg::CNT_W-1:0]     removed_count,
  output logic        [bdq_pkg::CNT_W-1:0]     new_length,
  output logic signed [bdq_pkg::DATA_W-1:0]    element,
  output logic                                 last
);
  import bdq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // sequencer and store state
  state_t            state, state_next;
  logic [FUNC_W-1:0] op;
  logic [DATA_W-1:0] key;
  logic [AW-1:0]     head, head_next;
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     rd_idx, rd_idx_next;
  logic [CW-1:0]     wr_idx, wr_idx_next;
  logic              found, found_next;

  // shared address unit: logical index to physical RAM slot
  logic [CW-1:0]     addr_idx;
  logic [CW:0]       addr_sum;
  logic [AW-1:0]     addr_phys;
  logic [AW-1:0]     head_dec;

  // RAM port
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [DATA_W-1:0] mem_wd;
  logic [DATA_W-1:0] mem_q;

  // result staging
  logic              out_free;
  logic              emit;
  logic [STATUS_W-1:0] res_status;
  logic [CW-1:0]     res_removed;
  logic [CW-1:0]     res_length;
  logic [DATA_W-1:0] res_element;
  logic              res_last;

  logic              is_walk;
  logic              full;
  logic              empty;
  logic              match;
  logic              drop;
  logic              final_elem;

  assign in_ready   = (state == S_IDLE);
  assign out_free   = !out_valid || out_ready;
  assign full       = (count == CW'(CAPACITY));
  assign empty      = (count == '0);
  assign match      = (mem_q == key);
  assign drop       = match && ((op == FN_DEL_ALL) || !found);
  assign final_elem = ((rd_idx + CW'(1)) == count);
  assign head_dec   = (head == '0) ? AW'(CAPACITY - 1) : head - AW'(1);

  always_comb begin
    case (op) inside
      FN_DEL_FIRST, FN_DEL_ALL, FN_READ_OUT: is_walk = 1'b1;
      default:                               is_walk = 1'b0;
    endcase
  end

  // pick which logical index the adder works on this cycle
  always_comb begin
    unique case (state)
      S_EXEC:  addr_idx = (op == FN_POP_FRONT) ? CW'(1) : count;
      S_CMP:   addr_idx = wr_idx;
      default: addr_idx = rd_idx;
    endcase
  end

  // wrap once: head stays below CAPACITY and the index at most CAPACITY
  assign addr_sum  = (CW + 1)'(head) + (CW + 1)'(addr_idx);
  assign addr_phys = (addr_sum >= (CW + 1)'(CAPACITY)) ?
                     AW'(addr_sum - (CW + 1)'(CAPACITY)) : AW'(addr_sum);

  bdq_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_wa),
    .wdata (mem_wd),
    .raddr (addr_phys),
    .rdata (mem_q)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (is_walk) begin
          state_next = S_RD;
        end else if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_RD: begin
        if (rd_idx == count) begin
          state_next = S_DONE;
        end else if (op == FN_READ_OUT) begin
          state_next = S_OUT;
        end else begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        state_next = S_RD;
      end
      S_OUT: begin
        if (out_free) state_next = final_elem ? S_IDLE : S_RD;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and result control
  always_comb begin
    head_next   = head;
    count_next  = count;
    rd_idx_next = rd_idx;
    wr_idx_next = wr_idx;
    found_next  = found;
    mem_we      = 1'b0;
    mem_wa      = addr_phys;
    mem_wd      = key;
    emit        = 1'b0;
    res_status  = ST_DONE;
    res_removed = '0;
    res_length  = count;
    res_element = '0;
    res_last    = 1'b1;

    unique case (state)
      S_IDLE: begin
        rd_idx_next = '0;
        wr_idx_next = '0;
        found_next  = 1'b0;
      end
      S_EXEC: begin
        if (!is_walk && out_free) begin
          emit = 1'b1;
          unique case (op)
            FN_PUSH_BACK: begin
              if (full) begin
                res_status = ST_FULL;
              end else begin
                mem_we     = 1'b1;
                count_next = count + CW'(1);
                res_length = count + CW'(1);
              end
            end
            FN_PUSH_FRONT: begin
              if (full) begin
                res_status = ST_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_wa     = head_dec;
                head_next  = head_dec;
                count_next = count + CW'(1);
                res_length = count + CW'(1);
              end
            end
            FN_POP_FRONT: begin
              if (empty) begin
                res_status = ST_EMPTY;
              end else begin
                head_next   = addr_phys;
                count_next  = count - CW'(1);
                res_length  = count - CW'(1);
                res_removed = CW'(1);
              end
            end
            FN_POP_BACK: begin
              if (empty) begin
                res_status = ST_EMPTY;
              end else begin
                count_next  = count - CW'(1);
                res_length  = count - CW'(1);
                res_removed = CW'(1);
              end
            end
            default: begin
              res_status = ST_DONE;
            end
          endcase
        end
      end
      S_CMP: begin
        // keep: copy down to the compacted slot; drop: mark and skip
        rd_idx_next = rd_idx + CW'(1);
        if (drop) begin
          found_next = 1'b1;
        end else begin
          mem_we      = 1'b1;
          mem_wd      = mem_q;
          wr_idx_next = wr_idx + CW'(1);
        end
      end
      S_OUT: begin
        if (out_free) begin
          emit        = 1'b1;
          res_element = mem_q;
          res_last    = final_elem;
          rd_idx_next = rd_idx + CW'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          emit = 1'b1;
          if (op == FN_READ_OUT) begin
            res_status = ST_EMPTY;
          end else begin
            res_removed = rd_idx - wr_idx;
            res_length  = wr_idx;
            count_next  = wr_idx;
            res_status  = (rd_idx == wr_idx) ? ST_EMPTY : ST_DONE;
          end
        end
      end
      default: begin
        rd_idx_next = rd_idx;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      head      <= '0;
      out_valid <= 1'b0;
      rd_idx    <= '0;
      wr_idx    <= '0;
      found     <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      head      <= head_next;
      rd_idx    <= rd_idx_next;
      wr_idx    <= wr_idx_next;
      found     <= found_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // hold the request for the length of the operation
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op  <= func;
      key <= value;
    end
  end

  // output register: advance only on emit
  always_ff @(posedge clk) begin
    if (emit) begin
      status        <= res_status;
      removed_count <= CNT_W'(res_removed);
      new_length    <= CNT_W'(res_length);
      element       <= res_element;
      last          <= res_last;
    end
  end

  // the store never holds more than it can
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("count exceeds capacity");

  // the walk never moves the length until its result
  a_walk_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD || state == S_CMP || state == S_OUT) |=> $stable(count))
    else $error("count changed during a walk");

  // compaction never writes ahead of the read position
  a_compact_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (wr_idx <= rd_idx && rd_idx < count))
    else $error("compaction pointers out of order");

  // RAM writes stay inside the buffer
  a_write_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (AW + 1)'(mem_wa) < (AW + 1)'(CAPACITY))
    else $error("RAM write outside the buffer");

  // a result that is not the last one is always a good read out element
  a_multi_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> (status == ST_DONE && removed_count == '0))
    else $error("non-final result with bad status");

endmodule
